/* rtl/gcp_pkg.sv */
// Shared types, codes and helper functions of the grid collapse engine.
package gcp_pkg;

  localparam int unsigned GRID_SIDE_DEF   = 16;
  localparam int unsigned STACK_DEPTH_DEF = 1024;

  localparam logic [1:0] TILE_NONE = 2'd3;
  localparam logic [2:0] MASK_ALL  = 3'b111;
  localparam logic [2:0] BEST_INIT = 3'd4;

  typedef enum logic [1:0] {
    OP_STEP    = 2'd0,
    OP_READ    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    DIR_PX = 2'd0,
    DIR_MX = 2'd1,
    DIR_PY = 2'd2,
    DIR_MY = 2'd3
  } dir_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_S1_RD,
    ST_S1_EV,
    ST_MOD_K,
    ST_S2_RD,
    ST_S2_EV,
    ST_MOD_T,
    ST_POP,
    ST_Q_RD,
    ST_Q_EV,
    ST_NB_RD,
    ST_NB_EV,
    ST_REPORT_RD,
    ST_REPORT_EV,
    ST_DONE_RD,
    ST_DONE_EV,
    ST_READ_RD,
    ST_READ_EV,
    ST_FINISH
  } state_e;

  // Result beat, cell index in the lowest bits.
  typedef struct packed {
    logic       all_done;
    logic       restarted;
    logic       is_collapsed;
    logic [2:0] mask;
    logic [1:0] tile;
    logic [7:0] cell_idx;
  } res_t;

  function automatic logic [1:0] pop3(input logic [2:0] m);
    pop3 = 2'(m[0]) + 2'(m[1]) + 2'(m[2]);
  endfunction

  function automatic logic [1:0] low_tile(input logic [2:0] m);
    if (m[0]) low_tile = 2'd0;
    else if (m[1]) low_tile = 2'd1;
    else if (m[2]) low_tile = 2'd2;
    else low_tile = TILE_NONE;
  endfunction

  // Tile of the k-th set bit of m, counted from bit 0.
  function automatic logic [1:0] nth_tile(input logic [2:0] m, input logic [1:0] k);
    logic [1:0] j;
    logic [1:0] t;
    j = 2'd0;
    t = TILE_NONE;
    for (int b = 0; b < 3; b++) begin
      if (m[b]) begin
        if (j == k && t == TILE_NONE) t = 2'(b);
        j = j + 2'd1;
      end
    end
    nth_tile = t;
  endfunction

endpackage

/* rtl/gcp_mod_unit.sv */
// Shared restoring remainder unit: 16-bit word modulo a small divisor, one bit a cycle.
module gcp_mod_unit #(
  parameter int unsigned DW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [15:0]   dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] rem_o
);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [3:0]    cnt_q, cnt_d;
  logic [15:0]   dvd_q, dvd_d;
  logic [DW-1:0] div_q, div_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[15]};
    diff   = trial - {1'b0, div_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 4'd15;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[14:0], 1'b0};
      if (trial >= {1'b0, div_q}) rem_d = diff[DW-1:0];
      else rem_d = trial[DW-1:0];
      if (cnt_q == 4'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/gcp_seq.sv */
// Sequencer of the grid engine: grid and stack memories, scans and propagation walk.
module gcp_seq #(
  parameter int unsigned GRID_SIDE   = gcp_pkg::GRID_SIDE_DEF,
  parameter int unsigned STACK_DEPTH = gcp_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  logic [1:0]    op_i,
  input  logic [7:0]    sel_i,
  input  logic [15:0]   rc_i,
  input  logic [15:0]   rt_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output gcp_pkg::res_t res_o
);

  localparam int unsigned CELLS = GRID_SIDE * GRID_SIDE;
  localparam int unsigned CIW   = $clog2(CELLS);
  localparam int unsigned CNTW  = $clog2(CELLS + 1);
  localparam int unsigned XW    = $clog2(GRID_SIDE);
  localparam int unsigned SEW   = 2 * XW;
  localparam int unsigned SAW   = $clog2(STACK_DEPTH);
  localparam int unsigned SCW   = $clog2(STACK_DEPTH + 1);
  localparam logic [XW-1:0]  XMAX  = XW'(GRID_SIDE - 1);
  localparam logic [CIW-1:0] ILAST = CIW'(CELLS - 1);

  function automatic logic [CIW-1:0] cidx(input logic [XW-1:0] x, input logic [XW-1:0] y);
    logic [31:0] v;
    v = 32'(y) * GRID_SIDE + 32'(x);
    cidx = v[CIW-1:0];
  endfunction

  gcp_pkg::state_e state_q, state_d, clr_ret_q, clr_ret_d;

  logic [7:0]     sel_q, sel_d;
  logic [15:0]    rc_q, rc_d, rt_q, rt_d;
  logic [CIW-1:0] idx_q, idx_d;
  logic [XW-1:0]  x_q, x_d, y_q, y_d;
  logic [2:0]     best_q, best_d;
  logic [CNTW-1:0] cnt_q, cnt_d, k_q, k_d, seen_q, seen_d;
  logic [CIW-1:0] ch_idx_q, ch_idx_d;
  logic [XW-1:0]  ch_x_q, ch_x_d, ch_y_q, ch_y_d;
  logic [2:0]     ch_mask_q, ch_mask_d;
  gcp_pkg::res_t  res_q, res_d;
  logic           done_q, done_d;
  logic [SCW-1:0] sc_q, sc_d, sc_m1;
  logic [XW-1:0]  q_x_q, q_x_d, q_y_q, q_y_d;
  logic [XW-1:0]  n_x_q, n_x_d, n_y_q, n_y_d;
  logic [2:0]     forbid_q, forbid_d;
  gcp_pkg::dir_e  d_q, d_d;

  // Scan walk helpers.
  logic           last;
  logic [CIW-1:0] idx_nx;
  logic [XW-1:0]  x_nx, y_nx;

  // Grid memory: {collapsed, mask}.
  logic [3:0]     grid_mem [CELLS];
  logic           g_we;
  logic [CIW-1:0] g_waddr, g_raddr;
  logic [3:0]     g_wdata, g_rdata_q;

  // Work stack memory: {y, x}.
  logic [SEW-1:0] stk_mem [STACK_DEPTH];
  logic           s_we;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [SEW-1:0] s_wdata, s_rdata_q;

  // Shared remainder unit.
  logic            mod_start, mod_done;
  logic [15:0]     mod_dvd;
  logic [CNTW-1:0] mod_div, mod_rem;

  logic           g_coll;
  logic [2:0]     g_mask;
  logic [1:0]     g_pop;
  logic [2:0]     m_new;
  logic [1:0]     m_pop;
  logic           nb_ok;
  logic [XW-1:0]  nb_x, nb_y;
  logic [1:0]     tile_sel;
  logic [31:0]    sel32;

  gcp_mod_unit #(.DW(CNTW)) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dvd),
    .divisor_i  (mod_div),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  always_ff @(posedge clk_i) begin
    if (g_we) grid_mem[g_waddr] <= g_wdata;
    g_rdata_q <= grid_mem[g_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) stk_mem[s_waddr] <= s_wdata;
    s_rdata_q <= stk_mem[s_raddr];
  end

  always_comb begin
    last   = (idx_q == ILAST);
    idx_nx = idx_q + 1'b1;
    if (x_q == XMAX) begin
      x_nx = '0;
      y_nx = y_q + 1'b1;
    end else begin
      x_nx = x_q + 1'b1;
      y_nx = y_q;
    end
    g_coll = g_rdata_q[3];
    g_mask = g_rdata_q[2:0];
    g_pop  = gcp_pkg::pop3(g_mask);
    m_new  = g_mask & ~forbid_q;
    m_pop  = gcp_pkg::pop3(m_new);
    sc_m1  = sc_q - 1'b1;
    sel32  = 32'(sel_q);
    tile_sel = gcp_pkg::nth_tile(ch_mask_q, mod_rem[1:0]);
    nb_ok = 1'b0;
    nb_x  = q_x_q;
    nb_y  = q_y_q;
    case (d_q)
      gcp_pkg::DIR_PX: begin
        nb_ok = (q_x_q != XMAX);
        nb_x  = q_x_q + 1'b1;
      end
      gcp_pkg::DIR_MX: begin
        nb_ok = (q_x_q != '0);
        nb_x  = q_x_q - 1'b1;
      end
      gcp_pkg::DIR_PY: begin
        nb_ok = (q_y_q != XMAX);
        nb_y  = q_y_q + 1'b1;
      end
      gcp_pkg::DIR_MY: begin
        nb_ok = (q_y_q != '0);
        nb_y  = q_y_q - 1'b1;
      end
      default: nb_ok = 1'b0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    clr_ret_d = clr_ret_q;
    sel_d = sel_q;  rc_d = rc_q;  rt_d = rt_q;
    idx_d = idx_q;  x_d = x_q;    y_d = y_q;
    best_d = best_q; cnt_d = cnt_q; k_d = k_q; seen_d = seen_q;
    ch_idx_d = ch_idx_q; ch_x_d = ch_x_q; ch_y_d = ch_y_q; ch_mask_d = ch_mask_q;
    res_d = res_q; done_d = done_q; sc_d = sc_q;
    q_x_d = q_x_q; q_y_d = q_y_q; n_x_d = n_x_q; n_y_d = n_y_q;
    forbid_d = forbid_q; d_d = d_q;
    g_we = 1'b0; g_waddr = idx_q; g_wdata = {1'b0, gcp_pkg::MASK_ALL};
    g_raddr = idx_q;
    s_we = 1'b0; s_waddr = sc_q[SAW-1:0]; s_wdata = {ch_y_q, ch_x_q};
    s_raddr = sc_m1[SAW-1:0];
    mod_start = 1'b0; mod_dvd = rc_q; mod_div = cnt_q;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      gcp_pkg::ST_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = idx_q;
        g_wdata = {1'b0, gcp_pkg::MASK_ALL};
        idx_d   = idx_nx;
        if (last) begin
          idx_d = '0; x_d = '0; y_d = '0;
          state_d = clr_ret_q;
        end
      end

      gcp_pkg::ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          sel_d = sel_i; rc_d = rc_i; rt_d = rt_i;
          res_d = '{all_done: 1'b0, restarted: 1'b0, is_collapsed: 1'b0,
                    mask: 3'd0, tile: gcp_pkg::TILE_NONE, cell_idx: 8'd0};
          idx_d = '0; x_d = '0; y_d = '0;
          case (gcp_pkg::op_e'(op_i))
            gcp_pkg::OP_STEP: begin
              best_d = gcp_pkg::BEST_INIT;
              cnt_d  = '0;
              state_d = done_q ? gcp_pkg::ST_FINISH : gcp_pkg::ST_S1_RD;
            end
            gcp_pkg::OP_READ: begin
              res_d.cell_idx = sel_i;
              state_d = (32'(sel_i) < CELLS) ? gcp_pkg::ST_READ_RD : gcp_pkg::ST_FINISH;
            end
            gcp_pkg::OP_RESTART: begin
              done_d     = 1'b0;
              res_d.mask = gcp_pkg::MASK_ALL;
              clr_ret_d  = gcp_pkg::ST_FINISH;
              state_d    = gcp_pkg::ST_CLEAR;
            end
            default: state_d = gcp_pkg::ST_FINISH;
          endcase
        end
      end

      gcp_pkg::ST_S1_RD: begin
        g_raddr = idx_q;
        state_d = gcp_pkg::ST_S1_EV;
      end

      gcp_pkg::ST_S1_EV: begin
        if (!g_coll) begin
          if ({1'b0, g_pop} < best_q) begin
            best_d = {1'b0, g_pop};
            cnt_d  = CNTW'(1);
          end else if ({1'b0, g_pop} == best_q) begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        idx_d = idx_nx; x_d = x_nx; y_d = y_nx;
        state_d = gcp_pkg::ST_S1_RD;
        if (last) begin
          if (cnt_d == '0) begin
            done_d  = 1'b1;
            state_d = gcp_pkg::ST_FINISH;
          end else begin
            mod_start = 1'b1;
            mod_dvd   = rc_q;
            mod_div   = cnt_d;
            state_d   = gcp_pkg::ST_MOD_K;
          end
        end
      end

      gcp_pkg::ST_MOD_K: begin
        if (mod_done) begin
          k_d = mod_rem;
          seen_d = '0;
          idx_d = '0; x_d = '0; y_d = '0;
          state_d = gcp_pkg::ST_S2_RD;
        end
      end

      gcp_pkg::ST_S2_RD: begin
        g_raddr = idx_q;
        state_d = gcp_pkg::ST_S2_EV;
      end

      gcp_pkg::ST_S2_EV: begin
        idx_d = idx_nx; x_d = x_nx; y_d = y_nx;
        state_d = gcp_pkg::ST_S2_RD;
        if (!g_coll && {1'b0, g_pop} == best_q && seen_q == k_q) begin
          ch_idx_d = idx_q; ch_x_d = x_q; ch_y_d = y_q; ch_mask_d = g_mask;
          res_d.cell_idx = 8'(32'(idx_q));
          if (g_pop == 2'd0) begin
            // Chosen cell has no option left: start over.
            res_d.restarted = 1'b1;
            idx_d = '0;
            clr_ret_d = gcp_pkg::ST_REPORT_RD;
            state_d = gcp_pkg::ST_CLEAR;
          end else begin
            mod_start = 1'b1;
            mod_dvd   = rt_q;
            mod_div   = CNTW'(g_pop);
            state_d   = gcp_pkg::ST_MOD_T;
          end
        end else begin
          if (!g_coll && {1'b0, g_pop} == best_q) seen_d = seen_q + 1'b1;
          if (last) begin
            idx_d = '0; x_d = '0; y_d = '0;
            state_d = gcp_pkg::ST_DONE_RD;
          end
        end
      end

      gcp_pkg::ST_MOD_T: begin
        if (mod_done) begin
          res_d.tile = tile_sel;
          g_we    = 1'b1;
          g_waddr = ch_idx_q;
          g_wdata = {1'b1, 3'(3'b001 << tile_sel)};
          s_we    = 1'b1;
          s_waddr = '0;
          s_wdata = {ch_y_q, ch_x_q};
          sc_d    = SCW'(1);
          state_d = gcp_pkg::ST_POP;
        end
      end

      gcp_pkg::ST_POP: begin
        if (sc_q == '0) begin
          state_d = gcp_pkg::ST_REPORT_RD;
        end else begin
          s_raddr = sc_m1[SAW-1:0];
          sc_d    = sc_m1;
          state_d = gcp_pkg::ST_Q_RD;
        end
      end

      gcp_pkg::ST_Q_RD: begin
        q_x_d   = s_rdata_q[XW-1:0];
        q_y_d   = s_rdata_q[SEW-1:XW];
        g_raddr = cidx(s_rdata_q[XW-1:0], s_rdata_q[SEW-1:XW]);
        state_d = gcp_pkg::ST_Q_EV;
      end

      gcp_pkg::ST_Q_EV: begin
        if (!g_coll) begin
          state_d = gcp_pkg::ST_POP;
        end else begin
          forbid_d = g_mask;
          d_d      = gcp_pkg::DIR_PX;
          state_d  = gcp_pkg::ST_NB_RD;
        end
      end

      gcp_pkg::ST_NB_RD: begin
        if (nb_ok) begin
          n_x_d   = nb_x;
          n_y_d   = nb_y;
          g_raddr = cidx(nb_x, nb_y);
          state_d = gcp_pkg::ST_NB_EV;
        end else if (d_q == gcp_pkg::DIR_MY) begin
          state_d = gcp_pkg::ST_POP;
        end else begin
          d_d = gcp_pkg::dir_e'(d_q + 2'd1);
        end
      end

      gcp_pkg::ST_NB_EV: begin
        state_d = (d_q == gcp_pkg::DIR_MY) ? gcp_pkg::ST_POP : gcp_pkg::ST_NB_RD;
        d_d     = gcp_pkg::dir_e'(d_q + 2'd1);
        if (!g_coll) begin
          g_we    = 1'b1;
          g_waddr = cidx(n_x_q, n_y_q);
          g_wdata = {(m_pop == 2'd1), m_new};
          if (m_new == 3'd0) begin
            // Contradiction: reset the whole grid and drop the walk.
            res_d.restarted = 1'b1;
            sc_d      = '0;
            idx_d     = '0;
            clr_ret_d = gcp_pkg::ST_REPORT_RD;
            state_d   = gcp_pkg::ST_CLEAR;
          end else if (m_pop == 2'd1 && sc_q < SCW'(STACK_DEPTH)) begin
            s_we    = 1'b1;
            s_waddr = sc_q[SAW-1:0];
            s_wdata = {n_y_q, n_x_q};
            sc_d    = sc_q + 1'b1;
          end
        end
      end

      gcp_pkg::ST_REPORT_RD: begin
        g_raddr = ch_idx_q;
        state_d = gcp_pkg::ST_REPORT_EV;
      end

      gcp_pkg::ST_REPORT_EV: begin
        res_d.mask = g_mask;
        res_d.is_collapsed = g_coll;
        idx_d = '0; x_d = '0; y_d = '0;
        state_d = gcp_pkg::ST_DONE_RD;
      end

      gcp_pkg::ST_DONE_RD: begin
        g_raddr = idx_q;
        state_d = gcp_pkg::ST_DONE_EV;
      end

      gcp_pkg::ST_DONE_EV: begin
        idx_d = idx_nx;
        state_d = gcp_pkg::ST_DONE_RD;
        if (!g_coll) begin
          done_d  = 1'b0;
          state_d = gcp_pkg::ST_FINISH;
        end else if (last) begin
          done_d  = 1'b1;
          state_d = gcp_pkg::ST_FINISH;
        end
      end

      gcp_pkg::ST_READ_RD: begin
        g_raddr = sel32[CIW-1:0];
        state_d = gcp_pkg::ST_READ_EV;
      end

      gcp_pkg::ST_READ_EV: begin
        res_d.mask = g_mask;
        res_d.is_collapsed = g_coll;
        res_d.tile = g_coll ? gcp_pkg::low_tile(g_mask) : gcp_pkg::TILE_NONE;
        state_d = gcp_pkg::ST_FINISH;
      end

      gcp_pkg::ST_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = gcp_pkg::ST_IDLE;
      end

      default: state_d = gcp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    res_o = res_q;
    res_o.all_done = done_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gcp_pkg::ST_CLEAR;
      clr_ret_q <= gcp_pkg::ST_IDLE;
      idx_q     <= '0;
      done_q    <= 1'b0;
      sc_q      <= '0;
      d_q       <= gcp_pkg::DIR_PX;
    end else begin
      state_q   <= state_d;
      clr_ret_q <= clr_ret_d;
      idx_q     <= idx_d;
      done_q    <= done_d;
      sc_q      <= sc_d;
      d_q       <= d_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q <= sel_d; rc_q <= rc_d; rt_q <= rt_d;
    x_q <= x_d; y_q <= y_d;
    best_q <= best_d; cnt_q <= cnt_d; k_q <= k_d; seen_q <= seen_d;
    ch_idx_q <= ch_idx_d; ch_x_q <= ch_x_d; ch_y_q <= ch_y_d; ch_mask_q <= ch_mask_d;
    res_q <= res_d;
    q_x_q <= q_x_d; q_y_q <= q_y_d; n_x_q <= n_x_d; n_y_q <= n_y_d;
    forbid_q <= forbid_d;
  end

  a_mod_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_start |-> mod_div != '0)
    else $error("remainder unit started with zero divisor");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_q <= SCW'(STACK_DEPTH))
    else $error("work stack count beyond depth");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gcp_pkg::ST_IDLE || state_q == gcp_pkg::ST_FINISH) |-> !g_we && !s_we)
    else $error("grid or stack written while idle");

  a_mod_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == gcp_pkg::ST_MOD_K || state_q == gcp_pkg::ST_MOD_T))
    else $error("remainder result arrived outside a wait state");

endmodule

/* rtl/grid_collapse_propagate_engine.sv */
// Top level of the grid collapse engine: stream ports, command decode and result register.
//
// The engine keeps a GRID_SIDE x GRID_SIDE grid of cells, each with a three-color option
// mask and a collapsed mark, and works on one command beat at a time. After reset, and on a
// restart command, a chosen cell with no option left or a contradiction found during
// propagation, the grid is cleared in a pass over all GRID_SIDE*GRID_SIDE cells, during
// which no command is taken. A read command returns the mask and state of one selected
// cell. A step command runs a candidate scan over all cells, a pick in the shared remainder
// unit, the selection scan, a second pick in that unit for the tile choice, then a
// propagation walk that pops stack entries and visits their neighbors, and finally a
// completion scan; a step on a finished grid skips all of these and answers directly. The
// finished result sits in an output register, so the next command beat is accepted while
// the previous result still waits.
module grid_collapse_propagate_engine #(
  parameter int unsigned GRID_SIDE   = gcp_pkg::GRID_SIDE_DEF,
  parameter int unsigned STACK_DEPTH = gcp_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // From bit 0: op[1:0], cell_sel[9:2], rand_cell[25:10], rand_tile[41:26], zero pad.
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // From bit 0: cell_out[7:0], tile_out[9:8], mask_out[12:10], is_collapsed[13],
  // restarted[14], all_done[15].
  output logic [15:0] m_axis_tdata_o
);

  gcp_pkg::res_t res;
  gcp_pkg::res_t out_q;
  logic          res_valid;
  logic          res_ready;
  logic          out_valid_q, out_valid_d;

  gcp_seq #(
    .GRID_SIDE   (GRID_SIDE),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid_i),
    .cmd_ready_o (s_axis_tready_o),
    .op_i        (s_axis_tdata_i[1:0]),
    .sel_i       (s_axis_tdata_i[9:2]),
    .rc_i        (s_axis_tdata_i[25:10]),
    .rt_i        (s_axis_tdata_i[41:26]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // The result register frees up as soon as its beat is taken downstream.
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) out_valid_d = 1'b1;
    else if (m_axis_tready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule
